FILE: sv/pwu_pkg.sv
// Package for the particle weight update core.
// Holds sizes, codes, state types and constant tables; depends on nothing.
package pwu_pkg;

    localparam int LANDMARKS  = 1024;
    localparam int ADDR_W     = $clog2(LANDMARKS);
    localparam int SCAN_W     = $clog2(LANDMARKS + 1);
    localparam int COUNT_BITS = 10;
    localparam int OUT_CNT_W  = 10;
    localparam int ACC_W      = 40;
    localparam int LMC_W      = 11;
    localparam int CFG_IDX_W  = 3;

    localparam int HALF_PI    = 102944;
    localparam int RED_OFFSET = 8 * HALF_PI;
    localparam logic [30:0] Q30_ONE = 31'd1 << 30;

    typedef enum logic [1:0] {
        MODE_LM   = 2'd0,
        MODE_POSE = 2'd1,
        MODE_OBS  = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SENSOR_RANGE = 3'd0,
        CFG_INV_VAR_X    = 3'd1,
        CFG_INV_VAR_Y    = 3'd2,
        CFG_LOG_NORM     = 3'd3,
        CFG_LM_COUNT     = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TRIG,
        ST_XMUL,
        ST_XSUM,
        ST_SCAN,
        ST_SQ,
        ST_IV,
        ST_ACC
    } t_state;

    typedef enum logic [3:0] {
        TS_IDLE,
        TS_RED,
        TS_SQ,
        TS_X2,
        TS_DIV,
        TS_DIVC,
        TS_MUL,
        TS_MULW,
        TS_FIN
    } t_trig_state;

    typedef struct packed {
        logic               done;
        logic signed [17:0] sin_v;
        logic signed [17:0] cos_v;
    } t_trig_res;

    // Divisors of the Horner steps: sine first, then cosine.
    function automatic logic [6:0] div_const(input logic [2:0] k);
        logic [6:0] d;
        case (k)
            3'd0:    d = 7'd72;
            3'd1:    d = 7'd42;
            3'd2:    d = 7'd20;
            3'd3:    d = 7'd6;
            3'd4:    d = 7'd90;
            3'd5:    d = 7'd56;
            3'd6:    d = 7'd30;
            default: d = 7'd12;
        endcase
        return d;
    endfunction

    // Reciprocals floor(2^32 / divisor), matching div_const.
    function automatic logic [29:0] div_recip(input logic [2:0] k);
        logic [29:0] m;
        case (k)
            3'd0:    m = 30'd59652323;
            3'd1:    m = 30'd102261126;
            3'd2:    m = 30'd214748364;
            3'd3:    m = 30'd715827882;
            3'd4:    m = 30'd47721858;
            3'd5:    m = 30'd76695844;
            3'd6:    m = 30'd143165576;
            default: m = 30'd357913941;
        endcase
        return m;
    endfunction

endpackage

FILE: sv/pwu_lm_ram.sv
// Landmark store: one write port and one registered read port.
// Depends on pwu_pkg for the depth and address width.
module pwu_lm_ram (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [pwu_pkg::ADDR_W-1:0] i_waddr,
    input  logic signed [31:0]        i_wx,
    input  logic signed [31:0]        i_wy,
    input  logic [pwu_pkg::ADDR_W-1:0] i_raddr,
    output logic signed [31:0]        o_rx,
    output logic signed [31:0]        o_ry
);
    import pwu_pkg::*;

    logic [63:0] mem [LANDMARKS];
    logic [63:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= {i_wx, i_wy};
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rx = signed'(r_rdata[63:32]);
    assign o_ry = signed'(r_rdata[31:0]);

endmodule

FILE: sv/pwu_trig.sv
// Sine and cosine of the particle heading by quadrant reduction and Taylor series.
// A sequencer drives one shared multiplier; depends on pwu_pkg.
module pwu_trig (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [19:0]    i_heading,
    output pwu_pkg::t_trig_res    o_res
);
    import pwu_pkg::*;

    t_trig_state r_st, n_st;
    logic [20:0] r_a;
    logic [1:0]  r_quad;
    logic [30:0] r_x;
    logic [31:0] r_x2;
    logic [31:0] r_v;
    logic [30:0] r_t;
    logic [30:0] r_s30;
    logic [30:0] r_c30;
    logic [2:0]  r_k;
    logic [63:0] r_prod;
    t_trig_res   r_res;

    logic [31:0] w_ma, w_mb;
    logic [21:0] w_a0;
    logic [29:0] w_q0;
    logic [32:0] w_rem;
    logic [29:0] w_qc;
    logic [31:0] w_val;
    logic [30:0] w_p;
    logic [16:0] w_s, w_c;
    logic signed [17:0] w_ss, w_cs;

    always_comb begin
        n_st = r_st;
        case (r_st)
            TS_IDLE: if (i_start) n_st = TS_RED;
            TS_RED:  if (r_a < 21'(HALF_PI)) n_st = TS_SQ;
            TS_SQ:   n_st = TS_X2;
            TS_X2:   n_st = TS_DIV;
            TS_DIV:  n_st = TS_DIVC;
            TS_DIVC: n_st = TS_MUL;
            TS_MUL:  n_st = TS_MULW;
            TS_MULW: n_st = (r_k == 3'd7) ? TS_FIN : TS_DIV;
            TS_FIN:  n_st = TS_IDLE;
            default: n_st = TS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= TS_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_comb begin
        w_ma = r_x2;
        w_mb = 32'(r_t);
        case (r_st)
            TS_SQ: begin
                w_ma = 32'(r_x);
                w_mb = 32'(r_x);
            end
            TS_DIV: begin
                w_ma = r_v;
                w_mb = 32'(div_recip(r_k));
            end
            TS_MUL: begin
                w_ma = (r_k == 3'd3) ? 32'(r_x) : r_x2;
                w_mb = 32'(r_t);
            end
            default: begin
                w_ma = r_x2;
                w_mb = 32'(r_t);
            end
        endcase
    end

    assign w_a0  = 22'(i_heading) + 22'(RED_OFFSET);
    assign w_q0  = r_prod[61:32];
    assign w_rem = 33'(r_v) - (33'(w_q0) * 33'(div_const(r_k)));
    assign w_qc  = w_q0 + 30'(w_rem >= 33'(div_const(r_k)));
    assign w_val = r_prod[61:30];
    assign w_p   = w_val[31:1];
    assign w_s   = 17'((r_s30 + 31'd8192) >> 14);
    assign w_c   = 17'((r_c30 + 31'd8192) >> 14);
    assign w_ss  = signed'({1'b0, w_s});
    assign w_cs  = signed'({1'b0, w_c});

    always_ff @(posedge i_clk) begin
        r_res.done <= 1'b0;
        if (!i_rst_n) begin
            r_res.sin_v <= '0;
            r_res.cos_v <= 18'sd65536;
        end else begin
            r_prod <= 64'(w_ma) * 64'(w_mb);
            case (r_st)
                TS_IDLE: begin
                    r_a    <= w_a0[20:0];
                    r_quad <= '0;
                end
                TS_RED: begin
                    if (r_a >= 21'(HALF_PI)) begin
                        r_a    <= r_a - 21'(HALF_PI);
                        r_quad <= r_quad + 2'd1;
                    end else begin
                        r_x <= 31'(r_a) << 14;
                    end
                end
                TS_X2: begin
                    r_x2 <= w_val;
                    r_v  <= w_val;
                    r_k  <= '0;
                end
                TS_DIVC: r_t <= Q30_ONE - 31'(w_qc);
                TS_MULW: begin
                    if (r_k == 3'd3) begin
                        r_s30 <= w_val[30:0];
                        r_v   <= r_x2;
                        r_k   <= r_k + 3'd1;
                    end else if (r_k == 3'd7) begin
                        r_c30 <= (w_p >= Q30_ONE) ? '0 : Q30_ONE - w_p;
                    end else begin
                        r_v <= w_val;
                        r_k <= r_k + 3'd1;
                    end
                end
                TS_FIN: begin
                    r_res.done <= 1'b1;
                    case (r_quad)
                        2'd0: begin
                            r_res.sin_v <= w_ss;
                            r_res.cos_v <= w_cs;
                        end
                        2'd1: begin
                            r_res.sin_v <= w_cs;
                            r_res.cos_v <= -w_ss;
                        end
                        2'd2: begin
                            r_res.sin_v <= -w_ss;
                            r_res.cos_v <= -w_cs;
                        end
                        default: begin
                            r_res.sin_v <= -w_cs;
                            r_res.cos_v <= w_ss;
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    assign o_res = r_res;

endmodule

FILE: sv/particle_weight_update_core.sv
// Top level of the particle weight update core.
// Instantiates pwu_trig and pwu_lm_ram; depends on pwu_pkg.
//
// One transaction is taken while busy is low. A landmark write does not raise busy,
// a pose runs through the sine and cosine sequencer, whose length is set by the
// quadrant reduction of the heading, and an observation scans the landmarks in use,
// reading one store entry per cycle through the single read port. The result of the
// last observation appears for one cycle on o_result_valid and cannot be held.
module particle_weight_update_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         i_mode,
    input  logic [9:0]                         i_slot,
    input  logic signed [31:0]                 i_pos_x,
    input  logic signed [31:0]                 i_pos_y,
    input  logic signed [19:0]                 i_heading,
    input  logic                               i_last_obs,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pwu_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [31:0]                        i_cfg_data,
    output logic                               o_result_valid,
    output logic signed [39:0]                 o_log_weight,
    output logic [9:0]                         o_obs_count,
    output logic [9:0]                         o_unmatched_count
);
    import pwu_pkg::*;

    localparam logic signed [42:0] ACC_HI = 43'((64'sd1 <<< (ACC_W - 1)) - 64'sd1);
    localparam logic signed [42:0] ACC_LO = 43'(-(64'sd1 <<< (ACC_W - 1)));
    localparam logic [40:0] HALF_MAX = 41'd1 << 40;

    t_state r_st, n_st;

    logic [30:0]        r_range;
    logic [23:0]        r_ivx, r_ivy;
    logic signed [23:0] r_log_norm;
    logic [LMC_W-1:0]   r_lm_count;

    logic signed [31:0] r_pose_x, r_pose_y;
    logic signed [17:0] r_cos, r_sin;
    logic signed [ACC_W-1:0] r_acc;
    logic [COUNT_BITS-1:0]   r_obs_cnt, r_unm_cnt;

    logic signed [31:0] r_ox, r_oy;
    logic               r_last;
    logic signed [49:0] r_pxc, r_pys, r_pxs, r_pyc;
    logic signed [34:0] r_mx, r_my;

    logic [SCAN_W-1:0]  r_rd_idx, r_scan_n;
    logic               r_v1, r_v2;
    logic [35:0]        r_ddx, r_ddy;
    logic [36:0]        r_best;
    logic [30:0]        r_bx, r_by;
    logic               r_found;

    logic [61:0]        r_sqx, r_sqy;
    logic [53:0]        r_hx, r_hy;
    logic [39:0]        r_lx, r_ly;

    logic               r_out_valid;
    logic signed [ACC_W-1:0] r_out_lw;
    logic [COUNT_BITS-1:0]   r_out_obs, r_out_unm;

    logic               w_accept;
    t_mode              w_mode;
    t_trig_res          w_trig;
    logic               w_trig_start;
    logic               w_lm_we;
    logic signed [31:0] w_rx, w_ry;
    logic               w_issue;
    logic               w_scan_end;
    logic signed [50:0] w_sx, w_sy;
    logic signed [35:0] w_dx, w_dy;
    logic [36:0]        w_d;
    logic [45:0]        w_qx, w_qy;
    logic [55:0]        w_sum;
    logic [54:0]        w_half_raw;
    logic [40:0]        w_half;
    logic signed [42:0] w_acc;
    logic signed [ACC_W-1:0] w_acc_sat;
    logic [COUNT_BITS-1:0]   w_obs_nx, w_unm_nx;

    assign w_accept     = start && !busy;
    assign w_mode       = t_mode'(i_mode);
    assign w_trig_start = w_accept && (w_mode == MODE_POSE);
    assign w_lm_we      = w_accept && (w_mode == MODE_LM) && (32'(i_slot) < LANDMARKS);
    assign w_issue      = (r_st == ST_SCAN) && (r_rd_idx < r_scan_n);
    assign w_scan_end   = (r_rd_idx == r_scan_n) && !r_v1 && !r_v2;

    pwu_trig u_trig (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_trig_start),
        .i_heading (i_heading),
        .o_res     (w_trig)
    );

    pwu_lm_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (w_lm_we),
        .i_waddr (ADDR_W'(i_slot)),
        .i_wx    (i_pos_x),
        .i_wy    (i_pos_y),
        .i_raddr (r_rd_idx[ADDR_W-1:0]),
        .o_rx    (w_rx),
        .o_ry    (w_ry)
    );

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: begin
                if (w_accept && w_mode == MODE_POSE) n_st = ST_TRIG;
                if (w_accept && w_mode == MODE_OBS)  n_st = ST_XMUL;
            end
            ST_TRIG: if (w_trig.done) n_st = ST_IDLE;
            ST_XMUL: n_st = ST_XSUM;
            ST_XSUM: n_st = ST_SCAN;
            ST_SCAN: if (w_scan_end) n_st = ST_SQ;
            ST_SQ:   n_st = ST_IV;
            ST_IV:   n_st = ST_ACC;
            ST_ACC:  n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    assign w_sx  = 51'(r_pxc) - 51'(r_pys) + 51'sd32768;
    assign w_sy  = 51'(r_pxs) + 51'(r_pyc) + 51'sd32768;
    assign w_dx  = 36'(r_mx) - 36'(w_rx);
    assign w_dy  = 36'(r_my) - 36'(w_ry);
    assign w_d   = 37'(r_ddx) + 37'(r_ddy);
    assign w_qx  = r_sqx[61:16];
    assign w_qy  = r_sqy[61:16];
    assign w_sum = 56'(r_hx) + 56'(r_lx[39:16]) + 56'(r_hy) + 56'(r_ly[39:16]);
    assign w_half_raw = w_sum[55:1];
    assign w_half = (w_half_raw > 55'(HALF_MAX)) ? HALF_MAX : w_half_raw[40:0];
    assign w_acc  = 43'(r_acc) - signed'(43'(w_half)) - 43'(r_log_norm);
    assign w_acc_sat = (w_acc > ACC_HI) ? ACC_W'(ACC_HI) :
                       (w_acc < ACC_LO) ? ACC_W'(ACC_LO) : ACC_W'(w_acc);
    assign w_obs_nx = (r_obs_cnt == '1) ? r_obs_cnt : r_obs_cnt + 1'b1;
    assign w_unm_nx = (r_unm_cnt == '1) ? r_unm_cnt : r_unm_cnt + 1'b1;

    always_ff @(posedge i_clk) begin
        r_out_valid <= 1'b0;
        if (!i_rst_n) begin
            r_range    <= 31'd3276800;
            r_ivx      <= 24'd65536;
            r_ivy      <= 24'd65536;
            r_log_norm <= '0;
            r_lm_count <= '0;
            r_pose_x   <= '0;
            r_pose_y   <= '0;
            r_cos      <= 18'sd65536;
            r_sin      <= '0;
            r_acc      <= '0;
            r_obs_cnt  <= '0;
            r_unm_cnt  <= '0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_rd_idx   <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_SENSOR_RANGE: r_range    <= i_cfg_data[30:0];
                    CFG_INV_VAR_X:    r_ivx      <= i_cfg_data[23:0];
                    CFG_INV_VAR_Y:    r_ivy      <= i_cfg_data[23:0];
                    CFG_LOG_NORM:     r_log_norm <= signed'(i_cfg_data[23:0]);
                    CFG_LM_COUNT:     r_lm_count <= i_cfg_data[LMC_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_v1 <= w_issue;
            r_v2 <= r_v1;
            case (r_st)
                ST_IDLE: begin
                    r_ox   <= i_pos_x;
                    r_oy   <= i_pos_y;
                    r_last <= i_last_obs;
                    if (w_accept && w_mode == MODE_POSE) begin
                        r_pose_x  <= i_pos_x;
                        r_pose_y  <= i_pos_y;
                        r_acc     <= '0;
                        r_obs_cnt <= '0;
                        r_unm_cnt <= '0;
                    end
                end
                ST_TRIG: begin
                    if (w_trig.done) begin
                        r_sin <= w_trig.sin_v;
                        r_cos <= w_trig.cos_v;
                    end
                end
                ST_XMUL: begin
                    r_pxc <= 50'(r_ox) * 50'(r_cos);
                    r_pys <= 50'(r_oy) * 50'(r_sin);
                    r_pxs <= 50'(r_ox) * 50'(r_sin);
                    r_pyc <= 50'(r_oy) * 50'(r_cos);
                end
                ST_XSUM: begin
                    r_mx     <= 35'(w_sx >>> 16) + 35'(r_pose_x);
                    r_my     <= 35'(w_sy >>> 16) + 35'(r_pose_y);
                    r_best   <= 37'(r_range);
                    r_found  <= 1'b0;
                    r_bx     <= '0;
                    r_by     <= '0;
                    r_rd_idx <= '0;
                    r_scan_n <= (32'(r_lm_count) < LANDMARKS) ? SCAN_W'(r_lm_count)
                                                               : SCAN_W'(LANDMARKS);
                end
                ST_SCAN: begin
                    if (w_issue) begin
                        r_rd_idx <= r_rd_idx + 1'b1;
                    end
                    if (r_v1) begin
                        r_ddx <= w_dx[35] ? 36'(-w_dx) : 36'(w_dx);
                        r_ddy <= w_dy[35] ? 36'(-w_dy) : 36'(w_dy);
                    end
                    if (r_v2 && (w_d < r_best)) begin
                        r_best  <= w_d;
                        r_bx    <= r_ddx[30:0];
                        r_by    <= r_ddy[30:0];
                        r_found <= 1'b1;
                    end
                end
                ST_SQ: begin
                    r_sqx <= 62'(r_bx) * 62'(r_bx);
                    r_sqy <= 62'(r_by) * 62'(r_by);
                end
                ST_IV: begin
                    r_hx <= 54'(w_qx[45:16]) * 54'(r_ivx);
                    r_lx <= 40'(w_qx[15:0]) * 40'(r_ivx);
                    r_hy <= 54'(w_qy[45:16]) * 54'(r_ivy);
                    r_ly <= 40'(w_qy[15:0]) * 40'(r_ivy);
                end
                ST_ACC: begin
                    if (r_last) begin
                        r_out_valid <= 1'b1;
                        r_out_lw    <= r_found ? w_acc_sat : r_acc;
                        r_out_obs   <= w_obs_nx;
                        r_out_unm   <= r_found ? r_unm_cnt : w_unm_nx;
                        r_acc       <= '0;
                        r_obs_cnt   <= '0;
                        r_unm_cnt   <= '0;
                    end else begin
                        r_obs_cnt <= w_obs_nx;
                        if (r_found) begin
                            r_acc <= w_acc_sat;
                        end else begin
                            r_unm_cnt <= w_unm_nx;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign busy              = (r_st != ST_IDLE);
    assign o_cfg_ready       = 1'b1;
    assign o_result_valid    = r_out_valid;
    assign o_log_weight      = r_out_lw;
    assign o_obs_count       = OUT_CNT_W'(r_out_obs);
    assign o_unmatched_count = OUT_CNT_W'(r_out_unm);

endmodule

FILE: sv/pwu_checker.sv
// Port-level checker for the particle weight update core, bound to the top level.
// Depends on pwu_pkg for the mode codes.
module pwu_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [1:0]                    i_mode,
    input logic                          o_result_valid,
    input logic [9:0]                    o_obs_count,
    input logic [9:0]                    o_unmatched_count
);
    import pwu_pkg::*;

    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result strobe without a transaction in progress");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe lasted more than one cycle");

    a_obs_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_mode == MODE_OBS) |=> busy)
        else $error("observation transaction did not raise busy");

    a_lm_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_mode == MODE_LM || i_mode == MODE_NONE)) |=> !busy)
        else $error("landmark write or unused mode held the block busy");

    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_obs_count != 10'd0 && o_unmatched_count <= o_obs_count))
        else $error("result counts are inconsistent");

endmodule

bind particle_weight_update_core pwu_checker u_pwu_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .i_mode            (i_mode),
    .o_result_valid    (o_result_valid),
    .o_obs_count       (o_obs_count),
    .o_unmatched_count (o_unmatched_count)
);
